### rtl/mqrb_pkg.sv
// shared constants and types of the multi-queue ring buffer
`timescale 1ns / 1ps
`default_nettype none

package mqrb_pkg;

    // defaults for the top-level parameters
    localparam int NumQueuesDefault    = 4;
    localparam int MaxDepthDefault     = 256;
    localparam int ElementWidthDefault = 32;

    // fixed field widths of the stream channels
    localparam int OpcodeW   = 2;
    localparam int SelectW   = 2;
    localparam int DataW     = 32;
    localparam int CountW    = 9;
    localparam int InUserW   = OpcodeW + SelectW;
    localparam int OutDataW  = 48;  // pop data and count, padded to whole bytes
    localparam int OutUserW  = 1;

    // size registers
    localparam int NumSizeRegs = 4;
    localparam int SizeRegW    = 4;
    localparam int CfgIndexW   = 2;
    localparam logic [SizeRegW-1:0] SizeReset = SizeRegW'(8);

    typedef enum logic [OpcodeW-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

endpackage

`default_nettype wire

### rtl/mqrb_ram.sv
// single-port element store with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mqrb_ram #(
    parameter int Depth = 1024,
    parameter int Width = 32,
    parameter int AddrW = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic             i_rd_en,
    input  wire logic [AddrW-1:0] i_addr,
    input  wire logic [Width-1:0] i_wr_data,
    output logic      [Width-1:0] o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/multi_queue_ring_buffer_top.sv
// top level of the multi-queue ring buffer
`timescale 1ns / 1ps
`default_nettype none

// Several circular fifos share one element store; queue q owns a region of
// MAXCAP entries, where MAXCAP is the largest power of two not above
// MAX_DEPTH, and uses the lowest 2**size_log2 of them (sizes above MAXCAP
// saturate). Each transfer on the input stream is one push, pop or count
// query and gives exactly one result transfer: accepted flag, popped element
// (zero unless a pop succeeded) and the count held after the operation.
// The block takes one operation per cycle while the result stream does not
// stall; a result passes through the registered read of the element store
// and then the output register. Write and read counters live in flops so
// the full/empty decision is made in the acceptance cycle; the store is a
// single-port memory, since each operation either writes or reads it.
// Writing a size register empties that queue; configuration writes are
// always taken and are meant to arrive only while the block is idle.

module multi_queue_ring_buffer_top
    import mqrb_pkg::*;
#(
    parameter int NUM_QUEUES    = NumQueuesDefault,
    parameter int MAX_DEPTH     = MaxDepthDefault,
    parameter int ELEMENT_WIDTH = ElementWidthDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // operation stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [DataW-1:0]     i_s_tdata,    // [31:0] push_data
    input  wire logic [InUserW-1:0]   i_s_tuser,    // [1:0] opcode, [3:2] queue_select
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [OutDataW-1:0]  o_m_tdata,    // [31:0] pop_data, [40:32] stored_count
    output logic      [OutUserW-1:0]  o_m_tuser,    // [0] accepted
    // size register writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CfgIndexW-1:0] i_cfg_index,
    input  wire logic [SizeRegW-1:0]  i_cfg_data
);

    // derived geometry
    localparam int CapLog2 = $clog2(MAX_DEPTH + 1) - 1;     // log2 of MAXCAP
    localparam int CW      = CapLog2 + 1;                   // free-running counter width
    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW      = QW + CapLog2;
    localparam int Depth   = NUM_QUEUES * (2 ** CapLog2);
    localparam int LgW     = $clog2(CapLog2 + 1);

    // control state
    logic [SizeRegW-1:0] r_size   [NumSizeRegs];
    logic [CW-1:0]       r_wr_cnt [NUM_QUEUES];
    logic [CW-1:0]       r_rd_cnt [NUM_QUEUES];

    // read stage and output register
    logic              r_p_valid;
    logic              r_p_acc;
    logic              r_p_pop;
    logic [CountW-1:0] r_p_cnt;
    logic              r_o_valid;
    logic              r_o_acc;
    logic [DataW-1:0]  r_o_data;
    logic [CountW-1:0] r_o_cnt;

    logic                    in_xfer;
    logic                    p_move;
    t_opcode                 op;
    logic [SelectW-1:0]      sel;
    logic [QW+SelectW-1:0]   sel_wide;
    logic                    q_valid;
    logic [QW-1:0]           q_idx;
    logic [CW-1:0]           wr_c;
    logic [CW-1:0]           rd_c;
    logic [CW-1:0]           cnt;
    logic [CW-1:0]           cnt_after;
    logic [SizeRegW-1:0]     size_lg;
    logic [LgW-1:0]          eff_lg;
    logic [CW-1:0]           cap;
    logic [CapLog2-1:0]      idx_mask;
    logic                    do_push;
    logic                    do_pop;
    logic                    acc;
    logic [CapLog2-1:0]      slot;
    logic [AW-1:0]           ram_addr;
    logic [ELEMENT_WIDTH+DataW-1:0] push_ext;
    logic [ELEMENT_WIDTH+DataW-1:0] pop_ext;
    logic [CW+CountW-1:0]    cnt_ext;
    logic [ELEMENT_WIDTH-1:0] rd_data;
    logic                    cfg_xfer;

    // handshakes: the read stage advances whenever the output slot is free
    assign p_move      = !r_o_valid || i_m_tready;
    assign o_s_tready  = !r_p_valid || p_move;
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid;

    // decode the operation
    assign op       = t_opcode'(i_s_tuser[OpcodeW-1:0]);
    assign sel      = i_s_tuser[InUserW-1:OpcodeW];
    assign sel_wide = (QW + SelectW)'(sel);
    assign q_valid  = int'(sel_wide) < NUM_QUEUES;
    assign q_idx    = sel_wide[QW-1:0];

    assign wr_c = r_wr_cnt[q_idx];
    assign rd_c = r_rd_cnt[q_idx];
    assign cnt  = wr_c - rd_c;      // wraps modulo twice the largest capacity

    // capacity, saturated at the region size
    assign size_lg  = r_size[sel];
    assign eff_lg   = (int'(size_lg) > CapLog2) ? LgW'(CapLog2) : LgW'(size_lg);
    assign cap      = CW'(1) << eff_lg;
    assign idx_mask = CapLog2'(cap - CW'(1));

    always_comb begin
        do_push   = 1'b0;
        do_pop    = 1'b0;
        acc       = 1'b0;
        cnt_after = cnt;
        if (q_valid) begin
            unique case (op)
                OP_PUSH: begin
                    do_push = cnt < cap;
                    acc     = do_push;
                    if (do_push) begin
                        cnt_after = cnt + CW'(1);
                    end
                end
                OP_POP: begin
                    do_pop = cnt != '0;
                    acc    = do_pop;
                    if (do_pop) begin
                        cnt_after = cnt - CW'(1);
                    end
                end
                OP_QUERY: begin
                    acc = 1'b1;
                end
                OP_NONE: begin
                    acc = 1'b0;
                end
                default: begin
                    acc = 1'b0;
                end
            endcase
        end else begin
            cnt_after = '0;
        end
    end

    // storage index: region base plus masked counter
    assign slot     = (op == OP_PUSH) ? (wr_c[CapLog2-1:0] & idx_mask)
                                      : (rd_c[CapLog2-1:0] & idx_mask);
    assign ram_addr = {q_idx, slot};
    assign push_ext = {{ELEMENT_WIDTH{1'b0}}, i_s_tdata};
    assign cnt_ext  = {{CountW{1'b0}}, cnt_after};

    mqrb_ram #(
        .Depth (Depth),
        .Width (ELEMENT_WIDTH),
        .AddrW (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && do_push),
        .i_rd_en   (in_xfer && do_pop),
        .i_addr    (ram_addr),
        .i_wr_data (push_ext[ELEMENT_WIDTH-1:0]),
        .o_rd_data (rd_data)
    );

    assign pop_ext = {{DataW{1'b0}}, rd_data};

    // size registers and queue counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumSizeRegs; i++) begin
                r_size[i] <= SizeReset;
            end
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_wr_cnt[q] <= '0;
                r_rd_cnt[q] <= '0;
            end
        end else if (cfg_xfer) begin
            r_size[i_cfg_index] <= i_cfg_data;
            // a register without a queue is stored but empties nothing
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (int'(i_cfg_index) == q) begin
                    r_wr_cnt[q] <= '0;
                    r_rd_cnt[q] <= '0;
                end
            end
        end else if (in_xfer) begin
            if (do_push) begin
                r_wr_cnt[q_idx] <= wr_c + CW'(1);
            end
            if (do_pop) begin
                r_rd_cnt[q_idx] <= rd_c + CW'(1);
            end
        end
    end

    // read stage: waits for the store's registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_p_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_p_acc <= acc;
            r_p_pop <= do_pop;
            r_p_cnt <= cnt_ext[CountW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move && r_p_valid) begin
            r_o_acc  <= r_p_acc;
            r_o_data <= r_p_pop ? pop_ext[DataW-1:0] : '0;
            r_o_cnt  <= r_p_cnt;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {(OutDataW - DataW - CountW)'(0), r_o_cnt, r_o_data};
    assign o_m_tuser  = r_o_acc;

endmodule

`default_nettype wire
